// ===== rtl/core/emi_pkg.sv =====
// Shared types and constants for the motion integrator.
// No dependencies; every other file imports this package.
package emi_pkg;

  localparam int DATA_W       = 32;
  localparam int ELAPSED_W    = 10;
  localparam int CFG_W        = 31;
  localparam int CFG_IDX_W    = 2;
  localparam int KIND_W       = 2;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAYFIELD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_EN   = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_FORCE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS_X,
    ST_POS_Y,
    ST_VEL_X,
    ST_VEL_Y,
    ST_MAX_SQ,
    ST_VX_SQ,
    ST_VY_SQ,
    ST_SUM,
    ST_CHECK,
    ST_DIV,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_SCALE_END,
    ST_WRAP,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/emi_ifs.sv =====
// Valid/ready channel interfaces for command and result beats.
// Depends on emi_pkg for field widths.
interface emi_cmd_if import emi_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [KIND_W-1:0]           kind;
  logic [ELAPSED_W-1:0]        elapsed_ms;
  logic signed [DATA_W-1:0]    vec_x;
  logic signed [DATA_W-1:0]    vec_y;

  modport source (output valid, kind, elapsed_ms, vec_x, vec_y, input ready);
  modport sink   (input valid, kind, elapsed_ms, vec_x, vec_y, output ready);
endinterface

interface emi_res_if import emi_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_W-1:0]    out_pos_x;
  logic signed [DATA_W-1:0]    out_pos_y;
  logic signed [DATA_W-1:0]    out_vel_x;
  logic signed [DATA_W-1:0]    out_vel_y;

  modport source (output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, input ready);
  modport sink   (input valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, output ready);
endinterface

// ===== rtl/core/emi_mul.sv =====
// Shared signed 32x32 multiplier with a registered product.
// Depends on emi_pkg.
module emi_mul import emi_pkg::*; (
  input  logic                       clk,
  input  logic signed [DATA_W-1:0]   a,
  input  logic signed [DATA_W-1:0]   b,
  output logic signed [2*DATA_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/core/emi_div.sv =====
// Serial restoring divider: floor(num * 2^FRAC_BITS / den), one bit per cycle.
// Expects num < den. Depends on emi_pkg.
module emi_div import emi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2*DATA_W-1:0]    num,
  input  logic [2*DATA_W-1:0]    den,
  output logic                   done,
  output logic [FRAC_BITS-1:0]   q
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [2*DATA_W-1:0]   rem;
  logic [2*DATA_W-1:0]   dvs;
  logic [2*DATA_W:0]     rem_sh;
  logic [2*DATA_W:0]     rem_sub;
  logic                  fits;

  assign rem_sh  = {rem, 1'b0};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign fits    = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dvs <= den;
      q   <= '0;
    end else if (busy) begin
      rem <= fits ? rem_sub[2*DATA_W-1:0] : rem_sh[2*DATA_W-1:0];
      q   <= {q[FRAC_BITS-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/entity_motion_integrator.sv =====
// Top level: 2D motion integrator with speed clamp and playfield wrap.
// Depends on emi_pkg, emi_ifs, emi_mul, emi_div.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------
//  cmd      | in  | kind, elapsed_ms, vec_x, vec_y
//  res      | out | out_pos_x, out_pos_y, out_vel_x, out_vel_y
//  cfg_*    | in  | register index and write data, no handshake
//
// move_to, apply_force and unused kinds go from idle straight to the done state.
// tick: multiplies, sum, check, then divide and scale if the speed clamp divides, wrap;
// the shared multiplier takes one product per cycle and the divider one quotient bit.
// cmd.ready is high only while idle; a finished result is held in the output
// register until res.ready, and the next item may already be working.
// Reset is synchronous: state and body registers clear to zero, config to defaults.
module entity_motion_integrator import emi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  emi_cmd_if.sink              cmd,
  emi_res_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic signed [2*DATA_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [2*DATA_W-1:0] SAT_MIN = -64'sd2147483648;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [2*DATA_W-1:0] v);
    if (v > SAT_MAX) return SAT_MAX[DATA_W-1:0];
    if (v < SAT_MIN) return SAT_MIN[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1])
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] scale_trunc(input logic signed [2*DATA_W-1:0] p);
    logic [2*DATA_W-1:0] mag;
    logic [2*DATA_W-1:0] sh;
    mag = p[2*DATA_W-1] ? 64'(-p) : 64'(p);
    sh  = mag >> FRAC_BITS;
    return p[2*DATA_W-1] ? DATA_W'(-sh) : DATA_W'(sh);
  endfunction

  function automatic logic signed [DATA_W-1:0] wrap_axis(input logic signed [DATA_W-1:0] p,
                                                        input logic [CFG_W-1:0] s);
    logic signed [DATA_W:0] pe;
    logic signed [DATA_W:0] se;
    pe = {p[DATA_W-1], p};
    se = {2'b00, s};
    if (p[DATA_W-1]) return DATA_W'(pe + se);
    if (pe > se)     return DATA_W'(pe - se);
    return p;
  endfunction

  state_t state, state_next;

  logic [CFG_W-1:0]            playfield_size;
  logic [CFG_W-1:0]            max_speed;
  logic                        wrap_enable;

  logic signed [DATA_W-1:0]    pos_x, pos_y, vel_x, vel_y, ext_acc_x, ext_acc_y;
  logic [ELAPSED_W-1:0]        elapsed;
  logic signed [DATA_W-1:0]    acc_x, acc_y;
  logic [2*DATA_W-1:0]         max_sq;
  logic [2*DATA_W-1:0]         spd_sq;

  logic signed [DATA_W-1:0]    mul_a, mul_b;
  logic signed [2*DATA_W-1:0]  mul_p;
  logic                        div_start;
  logic                        div_done;
  logic [FRAC_BITS-1:0]        ratio;
  logic                        accept;
  logic                        res_load;
  logic                        clamp;
  logic signed [DATA_W-1:0]    el_ext;
  logic signed [DATA_W-1:0]    ratio_ext;

  assign accept    = cmd.valid && cmd.ready;
  assign el_ext    = {{(DATA_W-ELAPSED_W){1'b0}}, elapsed};
  assign ratio_ext = {{(DATA_W-FRAC_BITS){1'b0}}, ratio};
  assign clamp     = (max_speed != '0) && (spd_sq > max_sq);

  emi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  emi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (max_sq),
    .den   (spd_sq),
    .done  (div_done),
    .q     (ratio)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) state_next = (cmd.kind == KIND_TICK) ? ST_POS_X : ST_DONE;
      end
      ST_POS_X: begin
        mul_a = vel_x; mul_b = el_ext; state_next = ST_POS_Y;
      end
      ST_POS_Y: begin
        mul_a = vel_y; mul_b = el_ext; state_next = ST_VEL_X;
      end
      ST_VEL_X: begin
        mul_a = acc_x; mul_b = el_ext; state_next = ST_VEL_Y;
      end
      ST_VEL_Y: begin
        mul_a = acc_y; mul_b = el_ext; state_next = ST_MAX_SQ;
      end
      ST_MAX_SQ: begin
        mul_a = {1'b0, max_speed}; mul_b = {1'b0, max_speed}; state_next = ST_VX_SQ;
      end
      ST_VX_SQ: begin
        mul_a = vel_x; mul_b = vel_x; state_next = ST_VY_SQ;
      end
      ST_VY_SQ: begin
        mul_a = vel_y; mul_b = vel_y; state_next = ST_SUM;
      end
      ST_SUM:   state_next = ST_CHECK;
      ST_CHECK: begin
        if (clamp) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_WRAP;
        end
      end
      ST_DIV:     if (div_done) state_next = ST_SCALE_X;
      ST_SCALE_X: begin
        mul_a = vel_x; mul_b = ratio_ext; state_next = ST_SCALE_Y;
      end
      ST_SCALE_Y: begin
        mul_a = vel_y; mul_b = ratio_ext; state_next = ST_SCALE_END;
      end
      ST_SCALE_END: state_next = ST_WRAP;
      ST_WRAP:      state_next = ST_DONE;
      ST_DONE: begin
        if (!res.valid || res.ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      playfield_size <= '1;
      max_speed      <= '0;
      wrap_enable    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLAYFIELD: playfield_size <= cfg_data;
        CFG_MAX_SPEED: max_speed      <= cfg_data;
        CFG_WRAP_EN:   wrap_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // body state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= '0;
      pos_y     <= '0;
      vel_x     <= '0;
      vel_y     <= '0;
      ext_acc_x <= '0;
      ext_acc_y <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd.kind)
              KIND_MOVE: begin
                pos_x <= cmd.vec_x;
                pos_y <= cmd.vec_y;
              end
              KIND_FORCE: begin
                ext_acc_x <= sat_add(ext_acc_x, cmd.vec_x);
                ext_acc_y <= sat_add(ext_acc_y, cmd.vec_y);
              end
              default: ;
            endcase
          end
        end
        ST_POS_X: begin
          ext_acc_x <= '0;
          ext_acc_y <= '0;
        end
        ST_POS_Y:     pos_x <= sat_add(pos_x, sat32(mul_p));
        ST_VEL_X:     pos_y <= sat_add(pos_y, sat32(mul_p));
        ST_VEL_Y:     vel_x <= sat_add(vel_x, sat32(mul_p));
        ST_MAX_SQ:    vel_y <= sat_add(vel_y, sat32(mul_p));
        ST_SCALE_Y:   vel_x <= scale_trunc(mul_p);
        ST_SCALE_END: vel_y <= scale_trunc(mul_p);
        ST_WRAP: begin
          if (wrap_enable) begin
            pos_x <= wrap_axis(pos_x, playfield_size);
            pos_y <= wrap_axis(pos_y, playfield_size);
          end
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          elapsed <= cmd.elapsed_ms;
          acc_x   <= cmd.vec_x;
          acc_y   <= cmd.vec_y;
        end
      end
      ST_POS_X: begin
        acc_x <= sat_add(acc_x, ext_acc_x);
        acc_y <= sat_add(acc_y, ext_acc_y);
      end
      ST_VX_SQ: max_sq <= mul_p;
      ST_VY_SQ: spd_sq <= mul_p;
      ST_SUM:   spd_sq <= spd_sq + mul_p;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.out_pos_x <= pos_x;
      res.out_pos_y <= pos_y;
      res.out_vel_x <= vel_x;
      res.out_vel_y <= vel_y;
    end
  end

endmodule
